[hdl/lkvc_pkg.sv]
package lkvc_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned CFG_W = 5;

  localparam logic [CFG_W-1:0] CAP_RESET  = 5'd16;
  localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMPARE,
    ST_SELECT,
    ST_READ,
    ST_WRITE
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic compare;
    logic select;
    logic read;
    logic write;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

[hdl/lkvc_ctrl.sv]
module lkvc_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  lkvc_pkg::status_t status_i,
  output lkvc_pkg::cmd_t    cmd_o
);

  lkvc_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lkvc_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = lkvc_pkg::ST_COMPARE;
        end
      end
      lkvc_pkg::ST_COMPARE: state_d = lkvc_pkg::ST_SELECT;
      lkvc_pkg::ST_SELECT:  state_d = lkvc_pkg::ST_READ;
      lkvc_pkg::ST_READ:    state_d = lkvc_pkg::ST_WRITE;
      lkvc_pkg::ST_WRITE: begin
        if (status_i.out_free) begin
          state_d = lkvc_pkg::ST_IDLE;
        end
      end
      default: state_d = lkvc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      lkvc_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      lkvc_pkg::ST_COMPARE: cmd_o.compare = 1'b1;
      lkvc_pkg::ST_SELECT:  cmd_o.select  = 1'b1;
      lkvc_pkg::ST_READ:    cmd_o.read    = 1'b1;
      lkvc_pkg::ST_WRITE:   cmd_o.write   = status_i.out_free;
      default: begin
        cmd_o      = '0;
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[hdl/lkvc_datapath.sv]
module lkvc_datapath #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lkvc_pkg::cmd_t                      cmd_i,
  output lkvc_pkg::status_t                   status_o,
  input  logic                                cfg_we_i,
  input  logic [lkvc_pkg::CFG_W-1:0]          cfg_data_i,
  input  logic                                op_i,
  input  logic [lkvc_pkg::KEY_W-1:0]          key_i,
  input  logic [lkvc_pkg::VAL_W-1:0]          value_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                out_hit_o,
  output logic [lkvc_pkg::VAL_W-1:0]          out_value_o
);

  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned RW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  logic [lkvc_pkg::CFG_W-1:0] cap_q;

  logic                       op_q;
  logic [lkvc_pkg::KEY_W-1:0] key_q;
  logic [lkvc_pkg::VAL_W-1:0] val_q;

  logic [lkvc_pkg::KEY_W-1:0] keys_q [MAX_ENTRIES];
  logic [RW-1:0]              rank_q [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0]     valid_q;
  logic [CW-1:0]              count_q;

  logic [lkvc_pkg::VAL_W-1:0] val_mem [MAX_ENTRIES];
  logic [lkvc_pkg::VAL_W-1:0] rd_data_q;

  logic [MAX_ENTRIES-1:0] match_q, victim_vec_q, free_vec_q;
  logic [MAX_ENTRIES-1:0] match_d, victim_vec_d;

  logic          hit_q;
  logic [IW-1:0] found_idx_q, victim_idx_q, free_idx_q;
  logic          hit_d;
  logic [IW-1:0] found_idx_d, victim_idx_d, free_idx_d;

  logic [IW-1:0] target_q, target_d;
  logic [CW-1:0] old_rank_q, old_rank_d;
  logic          update_q, update_d;
  logic          insert_q, insert_d;
  logic          new_key_q, new_key_d;

  logic [CW-1:0] cap_eff;

  logic                       out_valid_q;
  logic                       out_hit_q;
  logic [lkvc_pkg::VAL_W-1:0] out_value_q;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= lkvc_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_i;
      key_q <= key_i;
      val_q <= value_i;
    end
  end

  // Parallel key compare; the least recent valid entry holds rank count - 1.
  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      match_d[i]      = valid_q[i] && (keys_q[i] == key_q);
      victim_vec_d[i] = valid_q[i] && (CW'(rank_q[i]) == (count_q - CW'(1)));
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.compare) begin
      match_q      <= match_d;
      victim_vec_q <= victim_vec_d;
      free_vec_q   <= ~valid_q;
    end
  end

  // Lowest-index encoders.
  always_comb begin
    hit_d        = |match_q;
    found_idx_d  = '0;
    victim_idx_d = '0;
    free_idx_d   = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        found_idx_d = IW'(i);
      end
      if (victim_vec_q[i]) begin
        victim_idx_d = IW'(i);
      end
      if (free_vec_q[i]) begin
        free_idx_d = IW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.select) begin
      hit_q        <= hit_d;
      found_idx_q  <= found_idx_d;
      victim_idx_q <= victim_idx_d;
      free_idx_q   <= free_idx_d;
    end
  end

  always_comb begin
    if (lkvc_pkg::CFG_W'(0) == cap_q) begin
      cap_eff = CW'(1);
    end else if (32'(cap_q) > 32'(MAX_ENTRIES)) begin
      cap_eff = CW'(MAX_ENTRIES);
    end else begin
      cap_eff = CW'(cap_q);
    end
  end

  // Choose the slot to touch and the rank below which the other entries age.
  always_comb begin
    target_d   = found_idx_q;
    old_rank_d = CW'(rank_q[found_idx_q]);
    update_d   = hit_q || (op_q == lkvc_pkg::OP_PUT);
    insert_d   = 1'b0;
    new_key_d  = 1'b0;
    if (!hit_q && (op_q == lkvc_pkg::OP_PUT)) begin
      new_key_d = 1'b1;
      if (count_q >= cap_eff) begin
        target_d   = victim_idx_q;
        old_rank_d = count_q - CW'(1);
      end else begin
        target_d   = free_idx_q;
        old_rank_d = count_q;
        insert_d   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.read) begin
      rd_data_q  <= val_mem[found_idx_q];
      target_q   <= target_d;
      old_rank_q <= old_rank_d;
      update_q   <= update_d;
      insert_q   <= insert_d;
      new_key_q  <= new_key_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && (op_q == lkvc_pkg::OP_PUT)) begin
      val_mem[target_q] <= val_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write && new_key_q) begin
      keys_q[target_q] <= key_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
      count_q <= '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        rank_q[i] <= '0;
      end
    end else if (cmd_i.write && update_q) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (IW'(i) == target_q) begin
          rank_q[i] <= '0;
        end else if (valid_q[i] && (CW'(rank_q[i]) < old_rank_q)) begin
          rank_q[i] <= rank_q[i] + RW'(1);
        end
      end
      if (insert_q) begin
        valid_q[target_q] <= 1'b1;
        count_q           <= count_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.write) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      out_hit_q   <= hit_q;
      out_value_q <= (hit_q && (op_q == lkvc_pkg::OP_GET)) ? rd_data_q : lkvc_pkg::MISS_VALUE;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_hit_o   = out_hit_q;
  assign out_value_o = out_value_q;

endmodule

[hdl/lru_key_value_cache_unit.sv]
// Channel   Direction  Handshake                 Payload
// s_axis    in         s_axis_tvalid/tready      tuser: operation; tdata: key, value
// m_axis    out        m_axis_tvalid/tready      tuser: hit; tdata: read_value
// cfg       in         cfg_valid_i/cfg_ready_o   cfg_data_i: capacity_in_use
//
// An item runs through the accept step, then compares all keys, encodes the hit,
// victim and free slots, reads the value memory, and updates ranks and the slot, which
// also loads the result register. The next item is taken in
// the cycle after the result is loaded, even while that result still waits on m_axis.
// Reset clears all valid bits, ranks and the entry count at once.
// A stalled m_axis holds the unit in its final step until the result drains.
module lru_key_value_cache_unit #(
  parameter int unsigned MAX_ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // [31:0] key, [63:32] value
  input  logic [0:0]  s_axis_tuser,   // [0] operation
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] read_value
  output logic [0:0]  m_axis_tuser,   // [0] hit
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [4:0]  cfg_data_i
);

  lkvc_pkg::cmd_t    cmd;
  lkvc_pkg::status_t status;
  logic              out_hit;

  assign cfg_ready_o = 1'b1;

  lkvc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lkvc_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .op_i        (s_axis_tuser[0]),
    .key_i       (s_axis_tdata[31:0]),
    .value_i     (s_axis_tdata[63:32]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_hit_o   (out_hit),
    .out_value_o (m_axis_tdata)
  );

  assign m_axis_tuser[0] = out_hit;

endmodule
